### rtl/dsptu_pkg.sv
package dsptu_pkg;

   typedef logic [7:0]  char_type;
   typedef logic [31:0] secs_type;
   typedef logic [63:0] base_secs_type;
   typedef logic [29:0] nanos_type;

   localparam char_type CHAR_ZERO = 8'h30;
   localparam char_type CHAR_NINE = 8'h39;
   localparam char_type CHAR_WEEK = 8'h77;
   localparam char_type CHAR_DAY = 8'h64;
   localparam char_type CHAR_HOUR = 8'h68;
   localparam char_type CHAR_MINUTE = 8'h6d;
   localparam char_type CHAR_SECOND = 8'h73;

   localparam secs_type SECS_PER_WEEK = 32'd604800;
   localparam secs_type SECS_PER_DAY = 32'd86400;
   localparam secs_type SECS_PER_HOUR = 32'd3600;
   localparam secs_type SECS_PER_MINUTE = 32'd60;

   typedef struct packed {
      char_type      char_code;
      logic          is_last;
      base_secs_type base_seconds;
      nanos_type     base_nanoseconds;
   } req_item_type;

   typedef struct packed {
      logic          error;
      secs_type      week_seconds;
      secs_type      day_seconds;
      secs_type      hour_seconds;
      secs_type      minute_seconds;
      secs_type      plain_seconds;
      base_secs_type base_seconds;
      nanos_type     base_nanoseconds;
   } finish_type;

endpackage

### rtl/dsptu_if.sv
interface dsptu_req_if;
   import dsptu_pkg::*;

   logic          valid;
   logic          ready;
   char_type      char_code;
   logic          is_last;
   base_secs_type base_seconds;
   nanos_type     base_nanoseconds;

   modport source (output valid, output char_code, output is_last, output base_seconds,
                   output base_nanoseconds, input ready);
   modport sink (input valid, input char_code, input is_last, input base_seconds,
                 input base_nanoseconds, output ready);
endinterface

interface dsptu_rsp_if;
   import dsptu_pkg::*;

   logic          valid;
   logic          ready;
   logic          status;
   base_secs_type past_seconds;
   nanos_type     past_nanoseconds;

   modport source (output valid, output status, output past_seconds,
                   output past_nanoseconds, input ready);
   modport sink (input valid, input status, input past_seconds,
                 input past_nanoseconds, output ready);
endinterface

### rtl/dsptu_parser.sv
module dsptu_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  dsptu_pkg::req_item_type   in_item,
   output logic                      in_ready,
   output logic                      fin_valid,
   output dsptu_pkg::finish_type     fin_item,
   input  logic                      fin_ready
);
   import dsptu_pkg::*;

   secs_type   acc_ff, acc_in;
   secs_type   week_ff, week_in;
   secs_type   day_ff, day_in;
   secs_type   hour_ff, hour_in;
   secs_type   minute_ff, minute_in;
   secs_type   plain_ff, plain_in;
   logic       error_ff, error_in;
   logic       fin_valid_ff;
   finish_type fin_ff;

   logic       take;
   logic       is_digit;
   char_type   digit_diff;
   logic       err_upd;
   secs_type   acc_upd;

   assign in_ready = !in_item.is_last || !fin_valid_ff || fin_ready;
   assign take = in_valid && in_ready;
   assign fin_valid = fin_valid_ff;
   assign fin_item = fin_ff;

   assign is_digit = (in_item.char_code >= CHAR_ZERO) && (in_item.char_code <= CHAR_NINE);
   assign digit_diff = in_item.char_code - CHAR_ZERO;

   always_comb begin
      week_in = week_ff;
      day_in = day_ff;
      hour_in = hour_ff;
      minute_in = minute_ff;
      plain_in = plain_ff;
      err_upd = error_ff;
      acc_upd = '0;
      if (is_digit) begin
         acc_upd = {acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0} + {28'd0, digit_diff[3:0]};
      end else begin
         case (in_item.char_code)
            CHAR_WEEK: begin
               if ((day_ff | hour_ff | minute_ff | plain_ff) != '0) begin
                  err_upd = 1'b1;
               end
               week_in = acc_ff * SECS_PER_WEEK;
            end
            CHAR_DAY: begin
               if ((hour_ff | minute_ff | plain_ff) != '0) begin
                  err_upd = 1'b1;
               end
               day_in = acc_ff * SECS_PER_DAY;
            end
            CHAR_HOUR: begin
               if ((minute_ff | plain_ff) != '0) begin
                  err_upd = 1'b1;
               end
               hour_in = acc_ff * SECS_PER_HOUR;
            end
            CHAR_MINUTE: begin
               if (plain_ff != '0) begin
                  err_upd = 1'b1;
               end
               minute_in = acc_ff * SECS_PER_MINUTE;
            end
            CHAR_SECOND: begin
               plain_in = acc_ff;
            end
            default: begin
               err_upd = 1'b1;
            end
         endcase
      end
      acc_in = acc_upd;
      error_in = err_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         week_ff <= '0;
         day_ff <= '0;
         hour_ff <= '0;
         minute_ff <= '0;
         plain_ff <= '0;
         error_ff <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else begin
         if (take && in_item.is_last) begin
            fin_valid_ff <= 1'b1;
         end else if (fin_valid_ff && fin_ready) begin
            fin_valid_ff <= 1'b0;
         end
         if (take) begin
            if (in_item.is_last) begin
               acc_ff <= '0;
               week_ff <= '0;
               day_ff <= '0;
               hour_ff <= '0;
               minute_ff <= '0;
               plain_ff <= '0;
               error_ff <= 1'b0;
            end else begin
               acc_ff <= acc_in;
               week_ff <= week_in;
               day_ff <= day_in;
               hour_ff <= hour_in;
               minute_ff <= minute_in;
               plain_ff <= plain_in;
               error_ff <= error_in;
            end
         end
      end
   end

   // A string that ends on a digit is malformed.
   always_ff @(posedge clock) begin
      if (take && in_item.is_last) begin
         fin_ff.error <= error_in || is_digit;
         fin_ff.week_seconds <= week_in;
         fin_ff.day_seconds <= day_in;
         fin_ff.hour_seconds <= hour_in;
         fin_ff.minute_seconds <= minute_in;
         fin_ff.plain_seconds <= plain_in;
         fin_ff.base_seconds <= in_item.base_seconds;
         fin_ff.base_nanoseconds <= in_item.base_nanoseconds;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      take && in_item.is_last |=> acc_ff == '0 && !error_ff && week_ff == '0
         && day_ff == '0 && hour_ff == '0 && minute_ff == '0 && plain_ff == '0)
      else $error("parser state not cleared after the last item");

   assert property (@(posedge clock) disable iff (reset)
      $rose(fin_valid_ff) |-> $past(take && in_item.is_last))
      else $error("finish item without a last item");

   assert property (@(posedge clock) disable iff (reset)
      fin_valid_ff && !fin_ready |=> fin_valid_ff && $stable(fin_ff))
      else $error("stalled finish item lost or changed");

   assert property (@(posedge clock) disable iff (reset)
      take && !in_item.is_last && !is_digit |=> acc_ff == '0)
      else $error("number not cleared after a letter");

endmodule

### rtl/dsptu_result.sv
module dsptu_result (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fin_valid,
   input  dsptu_pkg::finish_type fin_item,
   output logic                  fin_ready,
   dsptu_rsp_if.source           rsp_ch
);
   import dsptu_pkg::*;

   logic          rsp_valid_ff;
   logic          status_ff;
   base_secs_type past_seconds_ff, past_seconds_in;
   nanos_type     past_nanoseconds_ff, past_nanoseconds_in;
   secs_type      total;

   assign fin_ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      total = fin_item.week_seconds + fin_item.day_seconds + fin_item.hour_seconds
            + fin_item.minute_seconds + fin_item.plain_seconds;
      if (fin_item.error) begin
         past_seconds_in = '0;
         past_nanoseconds_in = '0;
      end else begin
         past_seconds_in = fin_item.base_seconds - {32'd0, total};
         past_nanoseconds_in = fin_item.base_nanoseconds;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_valid && fin_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_valid && fin_ready) begin
         status_ff <= fin_item.error;
         past_seconds_ff <= past_seconds_in;
         past_nanoseconds_ff <= past_nanoseconds_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = status_ff;
   assign rsp_ch.past_seconds = past_seconds_ff;
   assign rsp_ch.past_nanoseconds = past_nanoseconds_ff;

   assert property (@(posedge clock) disable iff (reset)
      fin_valid && fin_ready |=> rsp_valid_ff)
      else $error("taken finish item did not reach the output");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fin_valid && fin_ready))
      else $error("result item without a finish item");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff |-> past_seconds_ff == '0 && past_nanoseconds_ff == '0)
      else $error("error result carries a nonzero time");

endmodule

### rtl/duration_string_to_past_time_unit.sv
// The last character passes the input, finish and result registers before the result
// item is valid. Throughput: one character per cycle, set by the parser's number and
// unit registers, which take one update per character; a last character waits while
// the previous finish item is held up. Reset is synchronous and active high; it clears
// the number, the unit values, the error flag and all valid flags.
module duration_string_to_past_time_unit (
   input  logic        clock,
   input  logic        reset,
   dsptu_req_if.sink   req_ch,
   dsptu_rsp_if.source rsp_ch
);
   import dsptu_pkg::*;

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         parser_ready;
   logic         fin_valid;
   logic         fin_ready;
   finish_type   fin_item;

   assign req_ch.ready = !in_valid_ff || parser_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_item_ff.char_code <= req_ch.char_code;
         in_item_ff.is_last <= req_ch.is_last;
         in_item_ff.base_seconds <= req_ch.base_seconds;
         in_item_ff.base_nanoseconds <= req_ch.base_nanoseconds;
      end
   end

   dsptu_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_item   (in_item_ff),
      .in_ready  (parser_ready),
      .fin_valid (fin_valid),
      .fin_item  (fin_item),
      .fin_ready (fin_ready)
   );

   dsptu_result u_result (
      .clock     (clock),
      .reset     (reset),
      .fin_valid (fin_valid),
      .fin_item  (fin_item),
      .fin_ready (fin_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

### tb/tb_duration_string_to_past_time_unit.sv
module tb_duration_string_to_past_time_unit;
   import dsptu_pkg::*;

   localparam secs_type DECIMAL_BASE = 32'd10;
   localparam int STRING_CHARS = 1250;
   localparam int MAX_GAP = 10;

   typedef char_type char_list_type[$];

   typedef struct packed {
      logic          status;
      base_secs_type seconds;
      nanos_type     nanoseconds;
   } past_time_type;

   logic clock;
   logic reset;

   dsptu_req_if req_if();
   dsptu_rsp_if rsp_if();

   duration_string_to_past_time_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   req_item_type  pending_chars[$];
   past_time_type expected_past_times[$];

   secs_type digits_value = '0;
   secs_type week_secs = '0;
   secs_type day_secs = '0;
   secs_type hour_secs = '0;
   secs_type minute_secs = '0;
   secs_type plain_secs = '0;
   logic     malformed = 1'b0;

   int chars_accepted = 0;
   int total_chars = 0;
   int bad_results = 0;
   int req_wait = 0;
   int rsp_wait = 0;
   int rsp_gap = 0;
   logic req_steady = 1'b0;
   logic rsp_steady = 1'b0;
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   req_item_type  next_char;
   past_time_type seen_time;
   past_time_type wanted_time;

   always #5 clock = ~clock;

   function automatic int draw_gap(input logic steady);
      return steady ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic char_list_type spell(input string text);
      char_list_type chars;
      for (int i = 0; i < text.len(); i++) begin
         chars.push_back(char_type'(text[i]));
      end
      return chars;
   endfunction

   function automatic base_secs_type random_base_secs();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return base_secs_type'($urandom_range(0, 100000));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic nanos_type random_nanos();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return nanos_type'(999999999);
         default: return nanos_type'($urandom_range(0, 999999999));
      endcase
   endfunction

   task automatic queue_duration(input char_list_type text, input base_secs_type base_secs,
                                 input nanos_type base_nanos);
      req_item_type item;
      for (int i = 0; i < text.size(); i++) begin
         item.char_code = text[i];
         item.is_last = (i == text.size() - 1);
         item.base_seconds = item.is_last ? base_secs : {$urandom, $urandom};
         item.base_nanoseconds = item.is_last ? base_nanos : random_nanos();
         pending_chars.push_back(item);
      end
   endtask

   task automatic append_digits(ref char_list_type text);
      int count;
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : $urandom_range(1, 3);
      repeat (count) text.push_back(CHAR_ZERO + char_type'($urandom_range(0, 9)));
   endtask

   task automatic queue_random_duration();
      char_list_type text;
      char_type      units[5];
      int            style;
      units = '{CHAR_WEEK, CHAR_DAY, CHAR_HOUR, CHAR_MINUTE, CHAR_SECOND};
      style = $urandom_range(0, 19);
      if (style < 13) begin
         foreach (units[u]) begin
            if ($urandom_range(0, 1) == 1) begin
               append_digits(text);
               text.push_back(units[u]);
            end
         end
         if (text.size() == 0) text.push_back(CHAR_SECOND);
      end else if (style < 16) begin
         repeat ($urandom_range(1, 5)) begin
            append_digits(text);
            text.push_back(units[$urandom_range(0, 4)]);
         end
      end else if (style < 18) begin
         repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 2))
               0: text.push_back(char_type'($urandom_range(0, 255)));
               1: text.push_back(CHAR_ZERO + char_type'($urandom_range(0, 9)));
               default: text.push_back(units[$urandom_range(0, 4)]);
            endcase
         end
      end else begin
         append_digits(text);
         text.push_back(units[$urandom_range(0, 4)]);
         if (style == 18) begin
            text.push_back(CHAR_ZERO + char_type'($urandom_range(0, 9)));
         end else begin
            text.push_back(char_type'($urandom_range(0, 255)));
            append_digits(text);
            text.push_back(CHAR_SECOND);
         end
      end
      queue_duration(text, random_base_secs(), random_nanos());
   endtask

   task automatic parse_duration_char(input req_item_type item);
      secs_type      number;
      secs_type      total;
      logic          is_digit;
      past_time_type outcome;
      number = digits_value;
      is_digit = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);
      if (is_digit) begin
         digits_value = number * DECIMAL_BASE + secs_type'(item.char_code - CHAR_ZERO);
      end else begin
         case (item.char_code)
            CHAR_WEEK: begin
               if ((day_secs | hour_secs | minute_secs | plain_secs) != '0) malformed = 1'b1;
               week_secs = number * SECS_PER_WEEK;
            end
            CHAR_DAY: begin
               if ((hour_secs | minute_secs | plain_secs) != '0) malformed = 1'b1;
               day_secs = number * SECS_PER_DAY;
            end
            CHAR_HOUR: begin
               if ((minute_secs | plain_secs) != '0) malformed = 1'b1;
               hour_secs = number * SECS_PER_HOUR;
            end
            CHAR_MINUTE: begin
               if (plain_secs != '0) malformed = 1'b1;
               minute_secs = number * SECS_PER_MINUTE;
            end
            CHAR_SECOND: begin
               plain_secs = number;
            end
            default: begin
               malformed = 1'b1;
            end
         endcase
         digits_value = '0;
      end
      if (item.is_last) begin
         if (is_digit) malformed = 1'b1;
         if (malformed) begin
            outcome = '{1'b1, 64'd0, 30'd0};
         end else begin
            total = week_secs + day_secs + hour_secs + minute_secs + plain_secs;
            outcome = '{1'b0, item.base_seconds - {32'd0, total}, item.base_nanoseconds};
         end
         expected_past_times.push_back(outcome);
         digits_value = '0;
         week_secs = '0;
         day_secs = '0;
         hour_secs = '0;
         minute_secs = '0;
         plain_secs = '0;
         malformed = 1'b0;
      end
   endtask

   task automatic flag_bad_result(input string cause, input past_time_type want,
                                  input past_time_type got);
      bad_results++;
      if (bad_results <= 10) begin
         $display("%s: expected status %0b past %0d s %0d ns, got status %0b past %0d s %0d ns",
                  cause, want.status, want.seconds, want.nanoseconds,
                  got.status, got.seconds, got.nanoseconds);
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_wait <= 0;
      end else begin
         if ($urandom_range(0, 39) == 0) req_steady <= !req_steady;
         if (!req_if.valid || req_taken) begin
            if (req_wait > 0) begin
               req_if.valid <= 1'b0;
               req_wait <= req_wait - 1;
            end else if (pending_chars.size() > 0) begin
               next_char = pending_chars.pop_front();
               req_if.char_code <= next_char.char_code;
               req_if.is_last <= next_char.is_last;
               req_if.base_seconds <= next_char.base_seconds;
               req_if.base_nanoseconds <= next_char.base_nanoseconds;
               req_if.valid <= 1'b1;
               req_wait <= draw_gap(req_steady);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_wait <= 0;
      end else begin
         if ($urandom_range(0, 39) == 0) rsp_steady <= !rsp_steady;
         if (rsp_taken) begin
            rsp_gap = draw_gap(rsp_steady);
            rsp_wait <= rsp_gap;
            rsp_if.ready <= (rsp_gap == 0);
         end else if (rsp_wait > 0) begin
            rsp_wait <= rsp_wait - 1;
            rsp_if.ready <= (rsp_wait == 1);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         rsp_taken <= rsp_if.valid && rsp_if.ready;
         if (req_if.valid && req_if.ready) begin
            parse_duration_char('{req_if.char_code, req_if.is_last, req_if.base_seconds,
                                  req_if.base_nanoseconds});
            chars_accepted++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            seen_time = '{rsp_if.status, rsp_if.past_seconds, rsp_if.past_nanoseconds};
            if (expected_past_times.size() == 0) begin
               flag_bad_result("Unexpected result item", '0, seen_time);
            end else begin
               wanted_time = expected_past_times.pop_front();
               if (seen_time !== wanted_time) begin
                  flag_bad_result("Result mismatch", wanted_time, seen_time);
               end
            end
         end
      end
   end

   initial begin
      char_list_type text;
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.char_code = '0;
      req_if.is_last = 1'b0;
      req_if.base_seconds = '0;
      req_if.base_nanoseconds = '0;
      rsp_if.ready = 1'b0;

      queue_duration(spell("1w2d3h4m5s"), '1, nanos_type'(999999999));
      queue_duration(spell("5s1m"), random_base_secs(), random_nanos());
      queue_duration(spell("0s1m"), random_base_secs(), random_nanos());
      queue_duration(spell("7"), random_base_secs(), random_nanos());
      queue_duration(spell("3m2m"), '0, random_nanos());
      queue_duration(spell("h"), '0, '0);
      text.push_back(8'h00);
      queue_duration(text, random_base_secs(), random_nanos());
      text = spell("s");
      text.push_back(8'hFF);
      queue_duration(text, random_base_secs(), random_nanos());

      while (pending_chars.size() < STRING_CHARS) queue_random_duration();
      total_chars = pending_chars.size();

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      while (chars_accepted < total_chars) @(posedge clock);
      while (expected_past_times.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (bad_results == 0) begin
         $display("duration_string_to_past_time_unit test passed");
      end else begin
         $display("duration_string_to_past_time_unit test failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("duration_string_to_past_time_unit test failed");
      $finish;
   end

endmodule
